>>> src/lcwr_pkg.sv
// ----------------------------------------------------------------------------
// lcwr_pkg
// Types and constants shared by the load cell weigh reader modules.
// ----------------------------------------------------------------------------
package lcwr_pkg;

   localparam int unsigned RAW_W      = 24;
   localparam int unsigned GRAMS_W    = 14;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned DIVISOR_W  = 16;
   localparam int unsigned BCD_STEPS  = 14;

   localparam logic [GRAMS_W-1:0]   WEIGHT_MAX    = 14'd9999;
   localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd430;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TARE      = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [1:0] STATUS_SATURATED = 2'd3;

   typedef struct packed {
      logic dout_level;
      logic cmd;
   } req_type;

   typedef struct packed {
      logic               sck_level;
      logic               reading_done;
      logic [1:0]         status_code;
      logic [RAW_W-1:0]   raw_reading;
      logic [GRAMS_W-1:0] weight_grams;
      logic [DIGIT_W-1:0] digit_thousands;
      logic [DIGIT_W-1:0] digit_hundreds;
      logic [DIGIT_W-1:0] digit_tens;
      logic [DIGIT_W-1:0] digit_ones;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOAD_BCD,
      ST_CONVERT,
      ST_DELIVER
   } ctrl_state_type;

   typedef struct packed {
      logic tick;
      logic load_fast;
      logic div_step;
      logic bcd_load;
      logic bcd_step;
      logic load_slow;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic slow;
      logic div_last;
      logic bcd_last;
   } ctrl_status_type;

endpackage

>>> src/lcwr_ctrl.sv
// ----------------------------------------------------------------------------
// lcwr_ctrl
// Sequencer: tick acceptance, divide and BCD conversion steps, result load.
// ----------------------------------------------------------------------------
module lcwr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lcwr_pkg::ctrl_status_type status,
   output lcwr_pkg::ctrl_cmd_type    cmd
);

   lcwr_pkg::ctrl_state_type state_ff;
   lcwr_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcwr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         lcwr_pkg::ST_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               cmd.tick = 1'b1;
               if (status.slow) begin
                  state_in = lcwr_pkg::ST_DIVIDE;
               end else begin
                  cmd.load_fast = 1'b1;
               end
            end
         end
         lcwr_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = lcwr_pkg::ST_LOAD_BCD;
            end
         end
         lcwr_pkg::ST_LOAD_BCD: begin
            cmd.bcd_load = 1'b1;
            state_in     = lcwr_pkg::ST_CONVERT;
         end
         lcwr_pkg::ST_CONVERT: begin
            cmd.bcd_step = 1'b1;
            if (status.bcd_last) begin
               state_in = lcwr_pkg::ST_DELIVER;
            end
         end
         lcwr_pkg::ST_DELIVER: begin
            if (status.out_free) begin
               cmd.load_slow = 1'b1;
               state_in      = lcwr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcwr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/lcwr_datapath.sv
// ----------------------------------------------------------------------------
// lcwr_datapath
// Serial read state, tare, restoring divider, BCD converter, result register.
// ----------------------------------------------------------------------------
module lcwr_datapath #(
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lcwr_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lcwr_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   input  logic [lcwr_pkg::DIVISOR_W-1:0]     csr_data,
   input  lcwr_pkg::ctrl_cmd_type             cmd,
   output lcwr_pkg::ctrl_status_type          status
);

   localparam int unsigned W   = SAMPLE_BITS;
   localparam int unsigned PW  = $clog2(SAMPLE_BITS + 2);
   localparam int unsigned CW  = $clog2(SAMPLE_BITS);
   localparam int unsigned DW  = lcwr_pkg::DIVISOR_W;
   localparam int unsigned GW  = lcwr_pkg::GRAMS_W;
   localparam int unsigned RW  = lcwr_pkg::RAW_W;
   localparam int unsigned QW  = SAMPLE_BITS + lcwr_pkg::GRAMS_W;
   localparam int unsigned BW  = 4 * lcwr_pkg::DIGIT_W;

   logic          phase_ff, phase_in;
   logic          clock_high_ff, clock_high_in;
   logic [PW-1:0] pulse_ff, pulse_in;
   logic [W-1:0]  shift_ff, shift_in;
   logic [W-1:0]  tare_ff, tare_in;
   logic          tare_pending_ff, tare_pending_in;
   logic [DW-1:0] divisor_ff;
   logic [W-1:0]  raw_ff;
   logic [W-1:0]  dvd_ff;
   logic [DW-1:0] rem_ff;
   logic [CW-1:0] div_cnt_ff;
   logic [GW-1:0] bin_ff;
   logic [GW-1:0] grams_ff;
   logic [BW-1:0] bcd_ff;
   logic [3:0]    bcd_cnt_ff;
   logic [1:0]    status_ff;
   logic          rsp_valid_ff;
   lcwr_pkg::rsp_type rsp_ff;

   logic          sck, done, tare_now;
   logic [1:0]    fast_status;
   logic [W-1:0]  raw;
   logic [W-1:0]  diff;
   logic [RW+W-1:0] raw_ext, raw_ff_ext;
   logic [DW-1:0] div_eff;
   logic [DW:0]   rem_sh;
   logic          qbit;
   logic [QW-1:0] q_ext;
   logic          q_sat;
   logic [BW-1:0] bcd_adj;

   assign tare_now = tare_pending_ff | req_data.cmd;

   always_comb begin
      phase_in      = phase_ff;
      clock_high_in = clock_high_ff;
      pulse_in      = pulse_ff;
      shift_in      = shift_ff;
      sck           = 1'b0;
      done          = 1'b0;
      raw           = '0;
      if (!phase_ff) begin
         clock_high_in = 1'b0;
         if (!req_data.dout_level) begin
            phase_in = 1'b1;
            pulse_in = '0;
            shift_in = '0;
         end
      end else if (!clock_high_ff) begin
         clock_high_in = 1'b1;
         sck           = 1'b1;
      end else begin
         clock_high_in = 1'b0;
         if (pulse_ff < PW'(SAMPLE_BITS)) begin
            shift_in = {shift_ff[W-2:0], req_data.dout_level};
         end
         pulse_in = pulse_ff + 1'b1;
         if (pulse_ff == PW'(SAMPLE_BITS)) begin
            phase_in = 1'b0;
            pulse_in = '0;
            done     = 1'b1;
            raw      = shift_ff ^ {1'b1, {(W-1){1'b0}}};
         end
      end
   end

   always_comb begin
      tare_in         = tare_ff;
      tare_pending_in = tare_now;
      fast_status     = lcwr_pkg::STATUS_OK;
      if (done) begin
         if (tare_now) begin
            tare_in         = raw;
            tare_pending_in = 1'b0;
            fast_status     = lcwr_pkg::STATUS_TARE;
         end else if (raw < tare_ff) begin
            fast_status = lcwr_pkg::STATUS_UNDERFLOW;
         end
      end
   end

   assign diff    = raw - tare_ff;
   assign raw_ext    = {{RW{1'b0}}, raw};
   assign raw_ff_ext = {{RW{1'b0}}, raw_ff};

   assign div_eff = (divisor_ff == '0) ? DW'(1) : divisor_ff;
   assign rem_sh  = {rem_ff, dvd_ff[W-1]};
   assign qbit    = rem_sh >= {1'b0, div_eff};

   assign q_ext = {{GW{1'b0}}, dvd_ff};
   assign q_sat = q_ext > QW'(lcwr_pkg::WEIGHT_MAX);

   always_comb begin
      bcd_adj = bcd_ff;
      for (int d = 0; d < 4; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= 1'b0;
         clock_high_ff   <= 1'b0;
         pulse_ff        <= '0;
         shift_ff        <= '0;
         tare_ff         <= '0;
         tare_pending_ff <= 1'b1;
      end else if (cmd.tick) begin
         phase_ff        <= phase_in;
         clock_high_ff   <= clock_high_in;
         pulse_ff        <= pulse_in;
         shift_ff        <= shift_in;
         tare_ff         <= tare_in;
         tare_pending_ff <= tare_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= lcwr_pkg::DIVISOR_RESET;
      end else if (csr_valid) begin
         divisor_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
         bcd_cnt_ff <= '0;
      end else begin
         if (cmd.tick) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         if (cmd.bcd_load) begin
            bcd_cnt_ff <= '0;
         end else if (cmd.bcd_step) begin
            bcd_cnt_ff <= bcd_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick) begin
         raw_ff <= raw;
         dvd_ff <= diff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[W-2:0], qbit};
         rem_ff <= qbit ? DW'(rem_sh - {1'b0, div_eff}) : rem_sh[DW-1:0];
      end
      if (cmd.bcd_load) begin
         bin_ff    <= q_sat ? lcwr_pkg::WEIGHT_MAX : q_ext[GW-1:0];
         grams_ff  <= q_sat ? lcwr_pkg::WEIGHT_MAX : q_ext[GW-1:0];
         status_ff <= q_sat ? lcwr_pkg::STATUS_SATURATED : lcwr_pkg::STATUS_OK;
         bcd_ff    <= '0;
      end else if (cmd.bcd_step) begin
         bcd_ff <= {bcd_adj[BW-2:0], bin_ff[GW-1]};
         bin_ff <= {bin_ff[GW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_fast || cmd.load_slow) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_fast) begin
         rsp_ff.sck_level       <= sck;
         rsp_ff.reading_done    <= done;
         rsp_ff.status_code     <= fast_status;
         rsp_ff.raw_reading     <= raw_ext[RW-1:0];
         rsp_ff.weight_grams    <= '0;
         rsp_ff.digit_thousands <= '0;
         rsp_ff.digit_hundreds  <= '0;
         rsp_ff.digit_tens      <= '0;
         rsp_ff.digit_ones      <= '0;
      end else if (cmd.load_slow) begin
         rsp_ff.sck_level       <= 1'b0;
         rsp_ff.reading_done    <= 1'b1;
         rsp_ff.status_code     <= status_ff;
         rsp_ff.raw_reading     <= raw_ff_ext[RW-1:0];
         rsp_ff.weight_grams    <= grams_ff;
         rsp_ff.digit_thousands <= bcd_ff[15:12];
         rsp_ff.digit_hundreds  <= bcd_ff[11:8];
         rsp_ff.digit_tens      <= bcd_ff[7:4];
         rsp_ff.digit_ones      <= bcd_ff[3:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.slow     = done && !tare_now && (raw >= tare_ff);
   assign status.div_last = div_cnt_ff == CW'(SAMPLE_BITS - 1);
   assign status.bcd_last = bcd_cnt_ff == 4'(lcwr_pkg::BCD_STEPS - 1);

endmodule

>>> src/load_cell_adc_weigh_reader_unit.sv
// ----------------------------------------------------------------------------
// load_cell_adc_weigh_reader_unit
// Bridge converter serial reader with tare, gram scaling and BCD digits.
// ----------------------------------------------------------------------------
// Each req transaction is one half-period tick of the converter serial clock
// with the sampled data line level and a tare request bit. Each tick returns
// exactly one rsp transaction with the clock level to drive next and, on the
// tick that ends the gain pulse, the finished reading.
// A tick that completes no divided reading gives its result in the
// registered output the cycle after acceptance; one tick per cycle is taken
// while the output register is free. A tick that completes a reading needing
// scaling runs a restoring divider, one quotient bit per cycle, then a 14-step
// binary to BCD converter; req_stall is high until its result is loaded.
// The csr channel writes grams_divisor (0 acts as 1); csr_ready is always
// high. Write it only while the block is idle.
// Reset (synchronous) sets the read idle, arms a tare capture, loads the
// divisor default and empties the output register.
// When rsp_stall holds, the result stays in the output register; the next
// tick is still accepted in the cycle the result is taken.
// ----------------------------------------------------------------------------
module load_cell_adc_weigh_reader_unit #(
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lcwr_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lcwr_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lcwr_pkg::DIVISOR_W-1:0] csr_data
);

   lcwr_pkg::ctrl_cmd_type    cmd;
   lcwr_pkg::ctrl_status_type status;

   assign csr_ready = 1'b1;

   lcwr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lcwr_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> sim/lcwr_weigh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcwr_weigh_checker
// Watches the tick, result and divisor channels of the weigh reader, models
// the serial read, tare and gram scaling per accepted tick, and compares every
// result field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lcwr_weigh_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  lcwr_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  lcwr_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [lcwr_pkg::DIVISOR_W-1:0] csr_data,
   output int                             fail_count,
   output int                             pending_count
);

   localparam int unsigned RAW_W     = lcwr_pkg::RAW_W;
   localparam int unsigned GRAMS_W   = lcwr_pkg::GRAMS_W;
   localparam int unsigned DIGIT_W   = lcwr_pkg::DIGIT_W;
   localparam int unsigned DIVISOR_W = lcwr_pkg::DIVISOR_W;
   localparam int unsigned PULSES    = RAW_W + 1;

   typedef enum logic {
      PHASE_WAIT,
      PHASE_CLOCK
   } read_phase_type;

   read_phase_type       read_phase;
   logic [4:0]           pulse_count;
   logic                 clock_high;
   logic [RAW_W-1:0]     shift_word;
   logic [RAW_W-1:0]     tare_value;
   logic                 tare_pending;
   logic [DIVISOR_W-1:0] grams_divisor;
   lcwr_pkg::rsp_type    pending_results[$];

   function automatic lcwr_pkg::rsp_type predict_tick(lcwr_pkg::req_type item);
      lcwr_pkg::rsp_type result;
      logic [RAW_W-1:0]  raw;
      logic [RAW_W-1:0]  quotient;
      logic [RAW_W-1:0]  divisor;
      result = '0;
      if (item.cmd) begin
         tare_pending = 1'b1;
      end
      if (read_phase != PHASE_CLOCK) begin
         clock_high = 1'b0;
         if (!item.dout_level) begin
            read_phase  = PHASE_CLOCK;
            pulse_count = '0;
            shift_word  = '0;
         end
      end else if (!clock_high) begin
         clock_high       = 1'b1;
         result.sck_level = 1'b1;
      end else begin
         clock_high = 1'b0;
         if (pulse_count < RAW_W) begin
            shift_word = {shift_word[RAW_W-2:0], item.dout_level};
         end
         pulse_count = pulse_count + 1'b1;
         if (pulse_count >= PULSES) begin
            read_phase          = PHASE_WAIT;
            pulse_count         = '0;
            raw                 = shift_word ^ (24'h1 << (RAW_W - 1));
            result.reading_done = 1'b1;
            result.raw_reading  = raw;
            if (tare_pending) begin
               tare_value         = raw;
               tare_pending       = 1'b0;
               result.status_code = lcwr_pkg::STATUS_TARE;
            end else if (raw < tare_value) begin
               result.status_code = lcwr_pkg::STATUS_UNDERFLOW;
            end else begin
               divisor  = (grams_divisor == '0) ? 24'd1 : RAW_W'(grams_divisor);
               quotient = (raw - tare_value) / divisor;
               if (quotient > RAW_W'(lcwr_pkg::WEIGHT_MAX)) begin
                  result.weight_grams = lcwr_pkg::WEIGHT_MAX;
                  result.status_code  = lcwr_pkg::STATUS_SATURATED;
               end else begin
                  result.weight_grams = quotient[GRAMS_W-1:0];
                  result.status_code  = lcwr_pkg::STATUS_OK;
               end
            end
            result.digit_thousands = DIGIT_W'(result.weight_grams / 1000);
            result.digit_hundreds  = DIGIT_W'((result.weight_grams / 100) % 10);
            result.digit_tens      = DIGIT_W'((result.weight_grams / 10) % 10);
            result.digit_ones      = DIGIT_W'(result.weight_grams % 10);
         end
      end
      return result;
   endfunction

   function automatic void check_field(string field, logic [31:0] expected,
                                       logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", field, expected, actual);
         fail_count = fail_count + 1;
      end
   endfunction

   always @(posedge clock) begin
      lcwr_pkg::rsp_type expected;
      if (reset) begin
         read_phase    = PHASE_WAIT;
         pulse_count   = '0;
         clock_high    = 1'b0;
         shift_word    = '0;
         tare_value    = '0;
         tare_pending  = 1'b1;
         grams_divisor = lcwr_pkg::DIVISOR_RESET;
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with no prediction outstanding");
               fail_count = fail_count + 1;
            end else begin
               expected = pending_results.pop_front();
               check_field("sck_level", expected.sck_level, rsp_data.sck_level);
               check_field("reading_done", expected.reading_done, rsp_data.reading_done);
               check_field("status_code", expected.status_code, rsp_data.status_code);
               check_field("raw_reading", expected.raw_reading, rsp_data.raw_reading);
               check_field("weight_grams", expected.weight_grams, rsp_data.weight_grams);
               check_field("digit_thousands", expected.digit_thousands,
                           rsp_data.digit_thousands);
               check_field("digit_hundreds", expected.digit_hundreds,
                           rsp_data.digit_hundreds);
               check_field("digit_tens", expected.digit_tens, rsp_data.digit_tens);
               check_field("digit_ones", expected.digit_ones, rsp_data.digit_ones);
            end
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(predict_tick(req_data));
         end
         if (csr_valid && csr_ready) begin
            grams_divisor = csr_data;
         end
      end
      pending_count <= pending_results.size();
   end

endmodule

>>> sim/tb_load_cell_adc_weigh_reader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_load_cell_adc_weigh_reader_unit
// Drives converter ticks framed as complete serial reads, tare requests and
// line noise through several divisor settings, with bursty ticks and random
// result stalls including one long hold-off; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb_load_cell_adc_weigh_reader_unit;

   localparam int unsigned RAW_W        = lcwr_pkg::RAW_W;
   localparam int unsigned DIVISOR_W    = lcwr_pkg::DIVISOR_W;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 48;
   localparam int unsigned PHASE_ITEMS  = 60;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int          NO_TARE      = -1;
   localparam int          LAST_TICK    = 50;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   lcwr_pkg::req_type    req_data    = '0;
   logic                 rsp_stall   = 1'b0;
   logic                 csr_valid   = 1'b0;
   logic [DIVISOR_W-1:0] csr_data    = '0;
   logic                 req_stall;
   logic                 rsp_valid;
   logic                 csr_ready;
   lcwr_pkg::rsp_type    rsp_data;
   int                   fail_count;
   int                   pending_count;

   int unsigned          cycle_count  = 0;
   int unsigned          items_sent   = 0;
   int unsigned          burst_left   = 0;
   logic                 squeeze_go   = 1'b0;
   logic                 squeeze_done = 1'b0;
   logic [RAW_W-1:0]     tare_mark    = '0;
   logic [DIVISOR_W-1:0] divisor_now  = lcwr_pkg::DIVISOR_RESET;

   always #2 clock = ~clock;

   load_cell_adc_weigh_reader_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   lcwr_weigh_checker weigh_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_tick(input logic dout, input logic tare_cmd);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= '{dout_level: dout, cmd: tare_cmd};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent = items_sent + 1;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end else begin
         burst_left = burst_left - 1;
      end
   endtask

   // tare_tick counts from the start tick (0) to the completing tick
   task automatic send_frame(input logic [RAW_W-1:0] reading, input int tare_tick);
      logic [RAW_W-1:0] word;
      int               idle_ticks;
      word       = reading ^ (24'h1 << (RAW_W - 1));
      idle_ticks = $urandom_range(1, 3);
      repeat (idle_ticks) send_tick(1'b1, 1'b0);
      send_tick(1'b0, tare_tick == 0);
      for (int i = 0; i < RAW_W; i++) begin
         send_tick(1'($urandom_range(0, 1)), tare_tick == 2 * i + 1);
         send_tick(word[RAW_W-1-i], tare_tick == 2 * i + 2);
      end
      send_tick(1'($urandom_range(0, 1)), tare_tick == LAST_TICK - 1);
      send_tick(1'($urandom_range(0, 1)), tare_tick == LAST_TICK);
   endtask

   task automatic send_noise();
      int unsigned count;
      count = $urandom_range(1, 30);
      repeat (count) send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      // flush any read left half done
      repeat (LAST_TICK + 1) send_tick(1'b1, 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_divisor(input logic [DIVISOR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      divisor_now  = value;
   endtask

   function automatic logic [RAW_W-1:0] aim_reading(input int unsigned kind);
      longint unsigned target;
      int unsigned     div_eff;
      int unsigned     grams;
      div_eff = (divisor_now == '0) ? 1 : 32'(divisor_now);
      case (kind)
         0: begin
            if ($urandom_range(0, 3) == 0) begin
               grams = $urandom_range(0, 1) ? 9999 : 0;
            end else begin
               grams = $urandom_range(0, 9999);
            end
            target = 64'(tare_mark) + 64'(grams * div_eff)
                   + 64'($urandom_range(0, div_eff - 1));
         end
         1: begin
            target = 64'(tare_mark) + 64'(10000 * div_eff)
                   + 64'($urandom_range(0, 1 << 20));
         end
         2: begin
            target = (tare_mark == '0) ? 64'd0 : 64'($urandom_range(0, tare_mark - 1));
         end
         default: begin
            target = 64'($urandom);
         end
      endcase
      if (target > 64'hFF_FFFF) begin
         target = 64'($urandom);
      end
      return target[RAW_W-1:0];
   endfunction

   initial begin : rsp_pacing
      int unsigned mode;
      int unsigned span;
      wait (reset == 1'b0);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 60);
         for (int i = 0; i < span; i++) begin
            @(posedge clock);
            if (squeeze_go && !squeeze_done) begin
               squeeze_done = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= 1'($urandom_range(0, 1));
               2:       rsp_stall <= (i % 4 == 3);
               default: rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [DIVISOR_W-1:0] divisor_plan[3];
      int unsigned          phase_start;
      int unsigned          pick;
      divisor_plan = '{16'd0, 16'd65535, 16'd0};
      divisor_plan[2] = DIVISOR_W'($urandom_range(2, 65534));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      tare_mark = '0;
      send_frame(24'h000000, NO_TARE);
      send_frame(24'hFFFFFF, NO_TARE);
      send_frame(24'h000000, NO_TARE);
      send_frame(24'(430 * 9999), NO_TARE);
      send_frame(24'(430 * 1234 + 429), NO_TARE);
      repeat (3) send_tick(1'b1, 1'b1);
      tare_mark = 24'h3FFFFF;
      send_frame(tare_mark, NO_TARE);
      send_frame(24'h3FFFFE, NO_TARE);
      tare_mark = 24'h123456;
      send_frame(tare_mark, LAST_TICK);
      send_frame(24'(24'h123456 + 430 * 10000), NO_TARE);
      send_noise();

      foreach (divisor_plan[p]) begin
         wait_drained();
         write_divisor(divisor_plan[p]);
         tare_mark = RAW_W'($urandom_range(0, 24'h7FFFFF));
         phase_start = items_sent;
         send_frame(tare_mark, $urandom_range(0, LAST_TICK));
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (p == 0 && items_sent - phase_start > PHASE_ITEMS / 2) begin
               squeeze_go = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               send_noise();
            end else if (pick == 1) begin
               tare_mark = RAW_W'($urandom_range(0, 24'h7FFFFF));
               send_frame(tare_mark, $urandom_range(0, LAST_TICK));
            end else begin
               pick = $urandom_range(0, 7);
               send_frame(aim_reading((pick < 4) ? 0 : pick - 3), NO_TARE);
            end
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
src/lcwr_pkg.sv
src/lcwr_ctrl.sv
src/lcwr_datapath.sv
src/load_cell_adc_weigh_reader_unit.sv
sim/lcwr_weigh_checker.sv
sim/tb_load_cell_adc_weigh_reader_unit.sv
